[hw/rtl/assert_macros.svh]
// Assertion macros shared by the matrix transform RTL.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define MVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define MVT_ASSERT_IMPL(label, ante, cons, msg) \
  `MVT_ASSERT(label, (ante) |-> (cons), msg)

`endif

[hw/rtl/mvt_pkg.sv]
// Shared types and constants for the 4x4 Q16.16 matrix-vector transform.
// Used by the channel interfaces and every module of the block.
package mvt_pkg;

  // Fixed-point format and matrix size.
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIM       = 4;
  localparam int IDX_W     = 2;

  // Number of vector inputs and result outputs carried by one item.
  localparam int NVEC      = 4;
  localparam int NRES      = 4;
  localparam int VEC_USED  = (DIM < NVEC) ? DIM : NVEC;
  localparam int NLANE     = (DIM < NRES) ? DIM : NRES;

  // Product and accumulator widths.
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(DIM);

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_COL   = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Saturation limits.
  localparam logic signed [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    logic valid;
    logic is_read;
  } stage_ctl_t;

endpackage

[hw/rtl/mvt_in_if.sv]
// Input channel of the matrix transform: valid/ready plus the item fields.
// Depends on mvt_pkg for the field types.
interface mvt_in_if import mvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [IDX_W-1:0] row_sel;
  logic [IDX_W-1:0] col_sel;
  elem_t            elem_value;
  elem_t            vec_x;
  elem_t            vec_y;
  elem_t            vec_z;
  elem_t            vec_w;

  modport source (
    output valid, op, row_sel, col_sel, elem_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, op, row_sel, col_sel, elem_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

[hw/rtl/mvt_out_if.sv]
// Result channel of the matrix transform: valid/ready plus the result fields.
// Depends on mvt_pkg for the field types.
interface mvt_out_if import mvt_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t res_x;
  elem_t res_y;
  elem_t res_z;
  elem_t res_w;
  logic  saturated;

  modport source (
    output valid, res_x, res_y, res_z, res_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, res_x, res_y, res_z, res_w, saturated,
    output ready
  );
endinterface

[hw/rtl/mvt_store.sv]
// Matrix element store: DIM x DIM registers cleared at reset, one write port,
// one indexed read port and the whole matrix for the lanes. Depends on mvt_pkg.
`include "assert_macros.svh"

module mvt_store import mvt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] wr_row_i,
  input  logic [IDX_W-1:0] wr_col_i,
  input  elem_t            wr_data_i,
  input  logic [IDX_W-1:0] rd_row_i,
  input  logic [IDX_W-1:0] rd_col_i,
  output elem_t            rd_data_o,
  output elem_t            mat_o [DIM][DIM]
);

  elem_t mat_q [DIM][DIM];

  // Element write; an index beyond the matrix matches no element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mat_q[r][c] <= '0;
        end
      end
    end else if (we_i) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          if (wr_row_i == IDX_W'(r) && wr_col_i == IDX_W'(c)) begin
            mat_q[r][c] <= wr_data_i;
          end
        end
      end
    end
  end

  // Indexed read; out-of-range indices read as zero.
  always_comb begin
    rd_data_o = '0;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (rd_row_i == IDX_W'(r) && rd_col_i == IDX_W'(c)) begin
          rd_data_o = mat_q[r][c];
        end
      end
    end
  end

  assign mat_o = mat_q;

  // A written element holds the written value on the following cycle.
  `MVT_ASSERT_IMPL(a_write_lands, we_i, ##1 (mat_q[$past(wr_row_i)][$past(wr_col_i)] == $past(wr_data_i)), "store write lost")

endmodule

[hw/rtl/mvt_lane.sv]
// One dot-product lane: DIM registered 32x32 products, then a registered sum.
// Depends on mvt_pkg for widths and types.
module mvt_lane import mvt_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  elem_t coef_i [DIM],
  input  elem_t vec_i  [DIM],
  output acc_t  sum_o
);

  prod_t prod_q [DIM];
  acc_t  sum_d;
  acc_t  sum_q;

  // Products of the coefficients and vector components.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < DIM; j++) begin
        prod_q[j] <= PROD_W'(coef_i[j]) * PROD_W'(vec_i[j]);
      end
    end
  end

  // Exact sum of the sign-extended products.
  always_comb begin
    sum_d = '0;
    for (int j = 0; j < DIM; j++) begin
      sum_d = sum_d + ACC_W'(prod_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

[hw/rtl/mvt_merge.sv]
// Merge stage: scales each lane sum back to Q16.16 and saturates it, or takes read
// data; gathers the result item and holds it in the output register. Depends on mvt_pkg.
`include "assert_macros.svh"

module mvt_merge import mvt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stage_ctl_t    ctl_i,
  input  elem_t         rd_data_i,
  input  acc_t          sum_i [NLANE],
  output logic          en_o,
  mvt_out_if.source     out_o
);

  logic  valid_q;
  logic  rd_q;
  elem_t res_d [NRES];
  elem_t res_q [NRES];
  logic  sat_d;
  logic  sat_q;
  acc_t  shifted;
  logic  fits;

  // The pipeline moves whenever the output register is free or being taken.
  assign en_o = !valid_q || out_o.ready;

  // Floor shift by the fraction width, then clip to 32 bits.
  always_comb begin
    res_d   = '{default: '0};
    sat_d   = 1'b0;
    shifted = '0;
    fits    = 1'b1;
    if (ctl_i.is_read) begin
      res_d[0] = rd_data_i;
    end else begin
      for (int i = 0; i < NLANE; i++) begin
        shifted = sum_i[i] >>> FRAC_BITS;
        fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
        if (fits) begin
          res_d[i] = shifted[DATA_W-1:0];
        end else begin
          res_d[i] = shifted[ACC_W-1] ? SAT_NEG : SAT_POS;
          sat_d    = 1'b1;
        end
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= ctl_i.valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      res_q <= res_d;
      sat_q <= sat_d;
      rd_q  <= ctl_i.is_read;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.res_x     = res_q[0];
  assign out_o.res_y     = res_q[1];
  assign out_o.res_z     = res_q[2];
  assign out_o.res_w     = res_q[3];
  assign out_o.saturated = sat_q;

  // A read result carries only the element in its first component.
  `MVT_ASSERT_IMPL(a_read_clean, valid_q && rd_q, (res_q[1] == '0) && (res_q[2] == '0) && (res_q[3] == '0) && !sat_q, "read result not clean")
  // A saturated transform has at least one component at a limit.
  `MVT_ASSERT_IMPL(a_sat_limit, valid_q && sat_q, (res_q[0] == SAT_POS) || (res_q[0] == SAT_NEG) || (res_q[1] == SAT_POS) || (res_q[1] == SAT_NEG) || (res_q[2] == SAT_POS) || (res_q[2] == SAT_NEG) || (res_q[3] == SAT_POS) || (res_q[3] == SAT_NEG), "saturation flag without clipped value")

endmodule

[hw/rtl/matrix_vector_transform_4x4.sv]
// Top level of the 4x4 Q16.16 matrix-vector transform.
// Depends on mvt_pkg, mvt_in_if, mvt_out_if, mvt_store, mvt_lane and mvt_merge.
//
// The block takes one item per clock cycle while the pipeline is not stalled. A
// write updates one matrix element and gives no result; it is seen by the very
// next item. A column or row transform, or an element read, moves down the
// pipeline registers to the output register. The sixteen parallel 32x32
// multipliers work in the cycle of acceptance and load the product registers.
// The four lane adders then load the lane sum registers, and scaling,
// saturation and the output register follow.
// Four lanes compute the four result components side by side, each over its
// row (column transform) or column (row transform) of the matrix. The whole
// pipeline stalls only while a result waits in the output register and the
// result side is not ready, so up to three results are in flight.
`include "assert_macros.svh"

module matrix_vector_transform_4x4 import mvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvt_in_if.sink    in_i,
  mvt_out_if.source out_o
);

  logic       en;
  logic       accept;
  elem_t      mat [DIM][DIM];
  elem_t      rd_data;
  elem_t      vin [NVEC];
  elem_t      vec [DIM];
  elem_t      coef [NLANE][DIM];
  acc_t       sum [NLANE];
  stage_ctl_t ctl0;
  stage_ctl_t ctl1_q;
  stage_ctl_t ctl2_q;
  elem_t      rd1_q;
  elem_t      rd2_q;

  assign in_i.ready = en;
  assign accept     = in_i.valid && en;

  // Matrix storage.
  mvt_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (accept && (in_i.op == OP_WRITE)),
    .wr_row_i  (in_i.row_sel),
    .wr_col_i  (in_i.col_sel),
    .wr_data_i (in_i.elem_value),
    .rd_row_i  (in_i.row_sel),
    .rd_col_i  (in_i.col_sel),
    .rd_data_o (rd_data),
    .mat_o     (mat)
  );

  // Vector components; those beyond the four inputs are zero.
  always_comb begin
    vin[0] = in_i.vec_x;
    vin[1] = in_i.vec_y;
    vin[2] = in_i.vec_z;
    vin[3] = in_i.vec_w;
    vec    = '{default: '0};
    for (int j = 0; j < VEC_USED; j++) begin
      vec[j] = vin[j];
    end
  end

  // Lane i takes row i for a column transform and column i for a row transform.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      for (int j = 0; j < DIM; j++) begin
        coef[i][j] = (in_i.op == OP_COL) ? mat[i][j] : mat[j][i];
      end
    end
  end

  // Parallel dot-product lanes.
  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    mvt_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .coef_i (coef[i]),
      .vec_i  (vec),
      .sum_o  (sum[i])
    );
  end

  // Every item but a write produces a result.
  always_comb begin
    ctl0.valid   = accept && (in_i.op != OP_WRITE);
    ctl0.is_read = (in_i.op == OP_READ);
  end

  // Control pipeline alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en) begin
      ctl1_q <= ctl0;
      ctl2_q <= ctl1_q;
    end
  end

  // Element read data follows the same pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      rd1_q <= rd_data;
      rd2_q <= rd1_q;
    end
  end

  // Scaling, saturation and output register.
  mvt_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl2_q),
    .rd_data_i (rd2_q),
    .sum_i     (sum),
    .en_o      (en),
    .out_o     (out_o)
  );

  // A stalled pipeline keeps the items in flight.
  `MVT_ASSERT_IMPL(a_stall_holds, !en, ##1 ($stable(ctl1_q) && $stable(ctl2_q)), "stall dropped an item")
  // A write never launches a result.
  `MVT_ASSERT_IMPL(a_write_silent, accept && (in_i.op == OP_WRITE), ##1 !ctl1_q.valid, "write produced a result")

endmodule
